FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, switched off while reset is held
`define TPF_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Concurrent check that also holds across reset
`define TPF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/tpf_pkg.sv
// Package for the text pattern finder: sizes, register indexes, cell types, byte helpers
`timescale 1ns / 1ps
`default_nettype none

package tpf_pkg;

    localparam int MAX_PATTERN  = 16;
    localparam int OFFSET_BITS  = 16;
    localparam int START_BITS   = 16;
    localparam int NUM_CELLS    = MAX_PATTERN + 1;
    localparam int LEN_BITS     = 5;
    localparam int PAT_IDX_BITS = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 64;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_PATTERN_LOW    = 3'd0,
        REG_PATTERN_HIGH   = 3'd1,
        REG_PATTERN_LENGTH = 3'd2,
        REG_MATCH_CASE     = 3'd3,
        REG_WHOLE_WORD     = 3'd4,
        REG_FIND_LAST      = 3'd5
    } tpf_reg_idx_t;

    typedef logic [7:0] tpf_byte_t;

    // what each cell is told to compare against
    typedef struct packed {
        logic      use1;
        logic      use2;
        tpf_byte_t pat1;
        tpf_byte_t pat2;
        logic      match_case;
    } tpf_cell_ctrl_t;

    // what each cell reports back
    typedef struct packed {
        logic ok1;
        logic ok2;
        logic alnum;
        logic valid;
    } tpf_cell_stat_t;

    function automatic logic is_alnum(input tpf_byte_t c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic tpf_byte_t fold(input tpf_byte_t c, input logic match_case);
        tpf_byte_t r;
        r = c;
        if (!match_case && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/tpf_cell.sv
// One window cell: holds a text byte, shifts it on, compares it with its pattern bytes
`timescale 1ns / 1ps
`default_nettype none

module tpf_cell (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    shift_en,
    input  wire logic                    clear,
    input  wire tpf_pkg::tpf_byte_t      in_byte,
    input  wire logic                    in_valid,
    input  wire tpf_pkg::tpf_cell_ctrl_t ctrl,
    output tpf_pkg::tpf_byte_t           out_byte,
    output logic                         out_valid,
    output tpf_pkg::tpf_cell_stat_t      stat
);

    tpf_pkg::tpf_byte_t byte_reg;
    logic               valid_reg;
    tpf_pkg::tpf_byte_t byte_fold;

    always_ff @(posedge aclk) begin
        if (shift_en) begin
            byte_reg <= in_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            valid_reg <= 1'b0;
        end else if (shift_en) begin
            valid_reg <= in_valid;
        end
    end

    always_comb begin
        byte_fold  = tpf_pkg::fold(byte_reg, ctrl.match_case);
        stat.valid = valid_reg;
        stat.alnum = tpf_pkg::is_alnum(byte_reg);
        stat.ok1   = !ctrl.use1 ||
                     (valid_reg && byte_fold == tpf_pkg::fold(ctrl.pat1, ctrl.match_case));
        stat.ok2   = !ctrl.use2 ||
                     (valid_reg && byte_fold == tpf_pkg::fold(ctrl.pat2, ctrl.match_case));
    end

    assign out_byte  = byte_reg;
    assign out_valid = valid_reg;

endmodule

`default_nettype wire

FILE: rtl/text_pattern_finder_core.sv
// Top level of the text pattern finder: config registers, cell chain, match keeping, result register
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  text    | s_valid s_ready s_text_byte s_end_of_text      | in
//  result  | m_valid m_ready m_found m_match_start          | out
//  config  | cfg_valid cfg_ready cfg_index cfg_data         | in
//
// One text word a cycle; all pattern positions are tested at once across the
// 17-cell window, and the result is loaded into the output register on the
// end-of-text word. s_ready drops only while a result waits and m_ready is low.
// Synchronous active-low reset clears config, window fill and the result.
// No clearing pass: each cell carries its own valid bit.
`timescale 1ns / 1ps
`default_nettype none

module text_pattern_finder_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [7:0]                          s_text_byte,
    input  wire logic                                s_end_of_text,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic                                     m_found,
    output logic [tpf_pkg::START_BITS-1:0]           m_match_start,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [tpf_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  wire logic [tpf_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int NC = tpf_pkg::NUM_CELLS;
    localparam int LB = tpf_pkg::LEN_BITS;
    localparam int OB = tpf_pkg::OFFSET_BITS;

    // configuration
    logic [63:0]   pat_low_reg;
    logic [63:0]   pat_high_reg;
    logic [LB-1:0] pat_len_reg;
    logic          match_case_reg;
    logic          whole_word_reg;
    logic          find_last_reg;

    // per-text state
    logic [OB-1:0] pos_reg, pos_next;
    logic [OB-1:0] best_reg, best_next;
    logic          have_reg, have_next;

    // result register
    logic                         m_valid_reg;
    logic                         m_found_reg;
    logic [tpf_pkg::START_BITS-1:0] m_start_reg;

    logic          accept;
    logic          last_acc;
    logic [LB-1:0] len_eff;
    logic [LB-1:0] len_m1;
    logic          len_nz;

    tpf_pkg::tpf_byte_t       pattern   [tpf_pkg::MAX_PATTERN];
    tpf_pkg::tpf_byte_t       chain_byte[NC+1];
    logic [NC:0]              chain_valid;
    tpf_pkg::tpf_cell_ctrl_t  cell_ctrl [NC];
    tpf_pkg::tpf_cell_stat_t  cell_stat [NC];
    logic [NC-1:0]            ok1_vec, ok2_vec, alnum_vec, valid_vec;

    logic          head_ok2;
    logic          cand1, cand2;
    logic [OB-1:0] start1, start2;
    logic          have_mid;
    logic [OB-1:0] best_mid;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pat_low_reg    <= '0;
            pat_high_reg   <= '0;
            pat_len_reg    <= '0;
            match_case_reg <= 1'b0;
            whole_word_reg <= 1'b0;
            find_last_reg  <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                tpf_pkg::REG_PATTERN_LOW:    pat_low_reg    <= cfg_data[63:0];
                tpf_pkg::REG_PATTERN_HIGH:   pat_high_reg   <= cfg_data[63:0];
                tpf_pkg::REG_PATTERN_LENGTH: pat_len_reg    <= cfg_data[LB-1:0];
                tpf_pkg::REG_MATCH_CASE:     match_case_reg <= cfg_data[0];
                tpf_pkg::REG_WHOLE_WORD:     whole_word_reg <= cfg_data[0];
                tpf_pkg::REG_FIND_LAST:      find_last_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_ready  = !m_valid_reg || m_ready;
    assign accept   = s_valid && s_ready;
    assign last_acc = accept && s_end_of_text;

    always_comb begin
        for (int k = 0; k < tpf_pkg::MAX_PATTERN; k++) begin
            pattern[k] = (k < 8) ? pat_low_reg[(k % 8) * 8 +: 8]
                                 : pat_high_reg[(k % 8) * 8 +: 8];
        end
    end

    // lengths above the maximum pattern length act as that maximum
    assign len_eff = (pat_len_reg > LB'(tpf_pkg::MAX_PATTERN)) ?
                     LB'(tpf_pkg::MAX_PATTERN) : pat_len_reg;
    assign len_nz  = (len_eff != '0);
    assign len_m1  = len_eff - LB'(1);

    assign chain_byte[0]  = s_text_byte;
    assign chain_valid[0] = 1'b1;

    // cell j holds the word j+1 places back from the incoming one.
    // Match ending on the previous word: cell j against pattern[len-1-j].
    // Match ending on the incoming word: cell j against pattern[len-2-j].
    for (genvar j = 0; j < NC; j++) begin : g_cell
        logic [LB-1:0] idx1, idx2;

        assign idx1 = len_eff - LB'(j + 1);
        assign idx2 = len_eff - LB'(j + 2);

        always_comb begin
            cell_ctrl[j].use1       = (LB'(j) < len_eff);
            cell_ctrl[j].use2       = (LB'(j + 1) < len_eff);
            cell_ctrl[j].pat1       = pattern[idx1[tpf_pkg::PAT_IDX_BITS-1:0]];
            cell_ctrl[j].pat2       = pattern[idx2[tpf_pkg::PAT_IDX_BITS-1:0]];
            cell_ctrl[j].match_case = match_case_reg;
        end

        tpf_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .shift_en  (accept),
            .clear     (last_acc),
            .in_byte   (chain_byte[j]),
            .in_valid  (chain_valid[j]),
            .ctrl      (cell_ctrl[j]),
            .out_byte  (chain_byte[j+1]),
            .out_valid (chain_valid[j+1]),
            .stat      (cell_stat[j])
        );

        assign ok1_vec[j]   = cell_stat[j].ok1;
        assign ok2_vec[j]   = cell_stat[j].ok2;
        assign alnum_vec[j] = cell_stat[j].alnum;
        assign valid_vec[j] = cell_stat[j].valid;
    end

    assign head_ok2 = tpf_pkg::fold(s_text_byte, match_case_reg) ==
                      tpf_pkg::fold(pattern[len_m1[tpf_pkg::PAT_IDX_BITS-1:0]],
                                    match_case_reg);

    always_comb begin
        cand1 = len_nz && (&ok1_vec);
        if (whole_word_reg && (tpf_pkg::is_alnum(s_text_byte) ||
                               (valid_vec[len_eff] && alnum_vec[len_eff]))) begin
            cand1 = 1'b0;
        end
        cand2 = s_end_of_text && len_nz && head_ok2 && (&ok2_vec);
        if (whole_word_reg && valid_vec[len_m1] && alnum_vec[len_m1]) begin
            cand2 = 1'b0;
        end
    end

    assign start1 = pos_reg - OB'(len_eff);
    assign start2 = start1 + OB'(1);

    // earlier candidate first, later one may override in last mode
    always_comb begin
        have_mid  = have_reg;
        best_mid  = best_reg;
        if (cand1 && (find_last_reg || !have_reg)) begin
            best_mid = start1;
        end
        have_mid  = have_reg || cand1;
        best_next = best_mid;
        if (cand2 && (find_last_reg || !have_mid)) begin
            best_next = start2;
        end
        have_next = have_mid || cand2;
        pos_next  = pos_reg + OB'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || last_acc) begin
            pos_reg  <= '0;
            best_reg <= '0;
            have_reg <= 1'b0;
        end else if (accept) begin
            pos_reg  <= pos_next;
            best_reg <= best_next;
            have_reg <= have_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (last_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (last_acc) begin
            m_found_reg <= have_next;
            m_start_reg <= have_next ? tpf_pkg::START_BITS'(best_next) : '0;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_match_start = m_start_reg;

endmodule

`default_nettype wire

FILE: rtl/tpf_checker.sv
// Port-level checks for the text pattern finder, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module tpf_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_valid,
    input wire logic                              s_ready,
    input wire logic                              s_end_of_text,
    input wire logic                              m_valid,
    input wire logic                              m_ready,
    input wire logic                              m_found,
    input wire logic [tpf_pkg::START_BITS-1:0]    m_match_start
);

    `TPF_ASSERT(a_hold_result, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_found) && $stable(m_match_start), "result word changed while stalled")
    `TPF_ASSERT(a_zero_start, aclk, aresetn, m_valid && !m_found |-> m_match_start == '0, "match start not zero without a match")
    `TPF_ASSERT(a_ready_free, aclk, aresetn, !s_ready |-> m_valid && !m_ready, "input stalled without a waiting result")
    `TPF_ASSERT(a_result_cause, aclk, aresetn, $rose(m_valid) |-> $past(s_valid && s_ready && s_end_of_text), "result without an end-of-text word")
    `TPF_ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_valid, "result valid after reset")

endmodule

bind text_pattern_finder_core tpf_checker u_tpf_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_end_of_text (s_end_of_text),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_found       (m_found),
    .m_match_start (m_match_start)
);

`default_nettype wire
